>>> design/pwsq_pkg.sv
package pwsq_pkg;

  localparam int NUM_WORKERS_DEF    = 8;
  localparam int NUM_PRIORITIES_DEF = 4;
  localparam int DEQUE_DEPTH_DEF    = 16;

  localparam int HANDLE_W    = 16;
  localparam int WORKER_W    = 4;
  localparam int PRIO_W      = 3;
  localparam int QIDX_W      = 3;
  localparam int ACTIVE_W    = 4;
  localparam int NORMAL_W    = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic {
    ACTION_SUBMIT = 1'b0,
    ACTION_FETCH  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_EMPTY      = 2'd2,
    STATUS_BAD_WORKER = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ACTIVE_WORKERS  = 1'b0,
    CFG_NORMAL_PRIORITY = 1'b1
  } cfg_index_t;

  typedef struct packed {
    action_t             action;
    logic [WORKER_W-1:0] worker;
    logic [PRIO_W-1:0]   priority_req;
    logic [HANDLE_W-1:0] job_handle;
  } req_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0] active_workers;
    logic [NORMAL_W-1:0] normal_priority;
  } cfg_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                found;
    logic                stolen;
    logic [QIDX_W-1:0]   queue_index;
    status_t             status;
  } result_t;

endpackage

>>> design/pwsq_store.sv
module pwsq_store #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/pwsq_seq.sv
module pwsq_seq #(
  parameter int NUM_WORKERS    = pwsq_pkg::NUM_WORKERS_DEF,
  parameter int NUM_PRIORITIES = pwsq_pkg::NUM_PRIORITIES_DEF,
  parameter int DEQUE_DEPTH    = pwsq_pkg::DEQUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pwsq_pkg::req_t    req,
  input  pwsq_pkg::cfg_t    cfg,
  output logic              done,
  input  logic              done_ack,
  output pwsq_pkg::result_t result
);

  localparam int ND   = NUM_WORKERS * NUM_PRIORITIES;
  localparam int WW   = $clog2(NUM_WORKERS);
  localparam int PRW  = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int DW   = $clog2(ND);
  localparam int PTRW = $clog2(DEQUE_DEPTH);
  localparam int CNTW = $clog2(DEQUE_DEPTH + 1);
  localparam int SW   = PTRW + 1;
  localparam int AW   = $clog2(ND * DEQUE_DEPTH);
  localparam int ACTW = pwsq_pkg::ACTIVE_W + 1;
  localparam int HW   = pwsq_pkg::HANDLE_W;
  localparam int QW   = pwsq_pkg::QIDX_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SUB   = 8'b0000_0010,
    S_OWN   = 8'b0000_0100,
    S_MOD   = 8'b0000_1000,
    S_VIC   = 8'b0001_0000,
    S_READ  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  pwsq_pkg::action_t   action_r, action_nxt;
  logic [WW-1:0]       w_r, w_nxt;
  logic [PRW-1:0]      prio_r, prio_nxt;
  logic [HW-1:0]       handle_r, handle_nxt;
  logic [PRW-1:0]      p_r, p_nxt;
  logic [WW-1:0]       v_r, v_nxt;
  logic [ACTW-1:0]     a_r, a_nxt;
  logic [WW-1:0]       mod_r, mod_nxt;
  logic [WW-1:0]       sub_cnt_r, sub_cnt_nxt;
  pwsq_pkg::result_t   res_r, res_nxt;

  logic [CNTW-1:0]     cnt_r [ND];
  logic [PTRW-1:0]     front_r [ND];
  logic [WW-1:0]       steal_off_r [NUM_WORKERS];

  logic [ACTW-1:0]     act;
  logic [PRW-1:0]      nrm;
  logic [PRW-1:0]      req_prio;
  logic                req_bad;
  logic [WW-1:0]       idx_w;
  logic [PRW-1:0]      idx_p;
  logic [DW-1:0]       cur_d;
  logic [CNTW-1:0]     cur_cnt;
  logic [PTRW-1:0]     cur_front;
  logic [PTRW-1:0]     front_dec;
  logic [PTRW-1:0]     front_inc;
  logic [SW-1:0]       back_sum;
  logic [PTRW-1:0]     back_slot;
  logic                cur_empty;
  logic                cur_full;
  logic                last_p;
  logic                mod_ge;
  logic [ACTW-1:0]     off_inc;
  logic [WW-1:0]       off_wrap;
  logic [ACTW-1:0]     v0_sum;
  logic [WW-1:0]       v0;
  logic [ACTW-1:0]     a_inc;
  logic [ACTW-1:0]     v_inc;
  logic [WW-1:0]       v_step;
  logic                adv;
  logic                cnt_we;
  logic [CNTW-1:0]     cnt_wd;
  logic                front_we;
  logic [PTRW-1:0]     front_wd;
  logic                sof_we;
  logic                mem_en;
  logic                mem_we;
  logic [PTRW-1:0]     mem_slot;
  logic [AW-1:0]       mem_addr;
  logic [HW-1:0]       mem_rdata;

  always_comb begin
    if (cfg.active_workers == '0) begin
      act = ACTW'(1);
    end else if ({1'b0, cfg.active_workers} > ACTW'(NUM_WORKERS)) begin
      act = ACTW'(NUM_WORKERS);
    end else begin
      act = {1'b0, cfg.active_workers};
    end
  end

  always_comb begin
    if (4'(cfg.normal_priority) >= 4'(NUM_PRIORITIES)) begin
      nrm = PRW'(NUM_PRIORITIES - 1);
    end else begin
      nrm = PRW'(cfg.normal_priority);
    end
    if (4'(req.priority_req) >= 4'(NUM_PRIORITIES)) begin
      req_prio = nrm;
    end else begin
      req_prio = PRW'(req.priority_req);
    end
  end

  assign req_bad   = {1'b0, req.worker} >= act;
  assign idx_w     = (state_r == S_VIC) ? v_r : w_r;
  assign idx_p     = (state_r == S_SUB) ? prio_r : p_r;
  assign cur_d     = DW'(idx_w) * DW'(NUM_PRIORITIES) + DW'(idx_p);
  assign cur_cnt   = cnt_r[cur_d];
  assign cur_front = front_r[cur_d];
  assign cur_empty = (cur_cnt == '0);
  assign cur_full  = (cur_cnt == CNTW'(DEQUE_DEPTH));
  assign last_p    = (p_r == PRW'(NUM_PRIORITIES - 1));
  assign front_dec = (cur_front == '0) ? PTRW'(DEQUE_DEPTH - 1) : cur_front - 1'b1;
  assign front_inc = (cur_front == PTRW'(DEQUE_DEPTH - 1)) ? '0 : cur_front + 1'b1;
  assign back_sum  = SW'(cur_front) + SW'(cur_cnt) - SW'(1);
  assign back_slot = (back_sum >= SW'(DEQUE_DEPTH)) ? PTRW'(back_sum - SW'(DEQUE_DEPTH))
                                                    : PTRW'(back_sum);

  assign mod_ge   = ACTW'(mod_r) >= act;
  assign off_inc  = ACTW'(mod_r) + ACTW'(1);
  assign off_wrap = (off_inc == act) ? '0 : WW'(off_inc);
  assign v0_sum   = ACTW'(w_r) + ACTW'(mod_r) + ACTW'(1);
  assign v0       = (v0_sum >= act) ? WW'(v0_sum - act) : WW'(v0_sum);
  assign a_inc    = a_r + ACTW'(1);
  assign v_inc    = ACTW'(v_r) + ACTW'(1);
  assign v_step   = (v_inc == act) ? '0 : WW'(v_inc);

  assign mem_addr = AW'(cur_d) * AW'(DEQUE_DEPTH) + AW'(mem_slot);

  always_comb begin
    state_nxt   = state_r;
    action_nxt  = action_r;
    w_nxt       = w_r;
    prio_nxt    = prio_r;
    handle_nxt  = handle_r;
    p_nxt       = p_r;
    v_nxt       = v_r;
    a_nxt       = a_r;
    mod_nxt     = mod_r;
    sub_cnt_nxt = sub_cnt_r;
    res_nxt     = res_r;
    cnt_we      = 1'b0;
    cnt_wd      = cur_cnt;
    front_we    = 1'b0;
    front_wd    = cur_front;
    sof_we      = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_slot    = cur_front;
    adv         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_nxt = req.action;
          handle_nxt = req.job_handle;
          prio_nxt   = req_prio;
          p_nxt      = '0;
          res_nxt    = '0;
          if (req.action == pwsq_pkg::ACTION_SUBMIT) begin
            if (req_bad) begin
              mod_nxt   = sub_cnt_r;
              state_nxt = S_MOD;
            end else begin
              w_nxt     = WW'(req.worker);
              state_nxt = S_SUB;
            end
          end else begin
            if (req_bad) begin
              res_nxt.status = pwsq_pkg::STATUS_BAD_WORKER;
              state_nxt      = S_DONE;
            end else begin
              w_nxt     = WW'(req.worker);
              state_nxt = S_OWN;
            end
          end
        end
      end
      S_SUB: begin
        res_nxt.handle      = handle_r;
        res_nxt.queue_index = QW'(w_r);
        res_nxt.stolen      = 1'b0;
        if (cur_full) begin
          res_nxt.found  = 1'b0;
          res_nxt.status = pwsq_pkg::STATUS_FULL;
        end else begin
          front_we       = 1'b1;
          front_wd       = front_dec;
          cnt_we         = 1'b1;
          cnt_wd         = cur_cnt + 1'b1;
          mem_en         = 1'b1;
          mem_we         = 1'b1;
          mem_slot       = front_dec;
          res_nxt.found  = 1'b1;
          res_nxt.status = pwsq_pkg::STATUS_OK;
        end
        state_nxt = S_DONE;
      end
      S_OWN: begin
        if (!cur_empty) begin
          front_we            = 1'b1;
          front_wd            = front_inc;
          cnt_we              = 1'b1;
          cnt_wd              = cur_cnt - 1'b1;
          mem_en              = 1'b1;
          mem_slot            = cur_front;
          res_nxt.found       = 1'b1;
          res_nxt.queue_index = QW'(w_r);
          res_nxt.status      = pwsq_pkg::STATUS_OK;
          state_nxt           = S_READ;
        end else if (last_p) begin
          if (act > ACTW'(1)) begin
            mod_nxt   = steal_off_r[w_r];
            state_nxt = S_MOD;
          end else begin
            res_nxt.queue_index = QW'(w_r);
            res_nxt.status      = pwsq_pkg::STATUS_EMPTY;
            state_nxt           = S_DONE;
          end
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_MOD: begin
        if (mod_ge) begin
          mod_nxt = WW'(ACTW'(mod_r) - act);
        end else if (action_r == pwsq_pkg::ACTION_SUBMIT) begin
          w_nxt       = mod_r;
          sub_cnt_nxt = off_wrap;
          state_nxt   = S_SUB;
        end else begin
          sof_we    = 1'b1;
          v_nxt     = v0;
          a_nxt     = '0;
          p_nxt     = '0;
          state_nxt = S_VIC;
        end
      end
      S_VIC: begin
        if (v_r == w_r) begin
          adv = 1'b1;
        end else if (!cur_empty) begin
          cnt_we              = 1'b1;
          cnt_wd              = cur_cnt - 1'b1;
          mem_en              = 1'b1;
          mem_slot            = back_slot;
          res_nxt.found       = 1'b1;
          res_nxt.stolen      = 1'b1;
          res_nxt.queue_index = QW'(v_r);
          res_nxt.status      = pwsq_pkg::STATUS_OK;
          state_nxt           = S_READ;
        end else if (last_p) begin
          p_nxt = '0;
          adv   = 1'b1;
        end else begin
          p_nxt = p_r + 1'b1;
        end
        if (adv) begin
          if (a_inc == act) begin
            res_nxt.queue_index = QW'(w_r);
            res_nxt.status      = pwsq_pkg::STATUS_EMPTY;
            state_nxt           = S_DONE;
          end else begin
            a_nxt = a_inc;
            v_nxt = v_step;
          end
        end
      end
      S_READ: begin
        res_nxt.handle = mem_rdata;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (done_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sub_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      sub_cnt_r <= sub_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    w_r      <= w_nxt;
    prio_r   <= prio_nxt;
    handle_r <= handle_nxt;
    p_r      <= p_nxt;
    v_r      <= v_nxt;
    a_r      <= a_nxt;
    mod_r    <= mod_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) begin
        cnt_r[i]   <= '0;
        front_r[i] <= '0;
      end
      for (int j = 0; j < NUM_WORKERS; j++) begin
        steal_off_r[j] <= '0;
      end
    end else begin
      if (cnt_we) begin
        cnt_r[cur_d] <= cnt_wd;
      end
      if (front_we) begin
        front_r[cur_d] <= front_wd;
      end
      if (sof_we) begin
        steal_off_r[w_r] <= off_wrap;
      end
    end
  end

  pwsq_store #(
    .DEPTH  (ND * DEQUE_DEPTH),
    .ADDR_W (AW),
    .DATA_W (HW)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (handle_r),
    .rdata (mem_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign done     = (state_r == S_DONE);
  assign result   = res_r;

endmodule

>>> design/priority_work_stealing_queues.sv
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid/in_ready    action, worker, priority_req, job_handle
// out      output     out_valid/out_ready  result_handle, found, stolen, queue_index, status
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time through a single deque sequencer that checks one deque per cycle.
// Submit: a worker out of range is replaced by the round-robin submit counter, reduced
// modulo the active count. Fetch: the own deques are scanned from priority 0 upward; a
// steal scans NUM_PRIORITIES deques per victim, and a steal offset left above the active
// count is first reduced by repeated subtraction of it.
// A finished result sits in the output register, so the next beat is taken meanwhile.
// Reset clears pointers, counts, steal offsets and the submit counter; no clearing pass.
module priority_work_stealing_queues #(
  parameter int NUM_WORKERS    = pwsq_pkg::NUM_WORKERS_DEF,
  parameter int NUM_PRIORITIES = pwsq_pkg::NUM_PRIORITIES_DEF,
  parameter int DEQUE_DEPTH    = pwsq_pkg::DEQUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [pwsq_pkg::WORKER_W-1:0]      in_worker,
  input  logic [pwsq_pkg::PRIO_W-1:0]        in_priority_req,
  input  logic [pwsq_pkg::HANDLE_W-1:0]      in_job_handle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pwsq_pkg::HANDLE_W-1:0]      out_result_handle,
  output logic                               out_found,
  output logic                               out_stolen,
  output logic [pwsq_pkg::QIDX_W-1:0]        out_queue_index,
  output logic [1:0]                         out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwsq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pwsq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pwsq_pkg::ACTIVE_W-1:0] active_workers_r;
  logic [pwsq_pkg::NORMAL_W-1:0] normal_priority_r;
  logic                          out_valid_r;
  pwsq_pkg::result_t             out_res_r;
  pwsq_pkg::req_t                req;
  pwsq_pkg::cfg_t                cfg;
  pwsq_pkg::result_t             seq_res;
  logic                          seq_done;
  logic                          done_ack;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_workers_r  <= pwsq_pkg::ACTIVE_W'(1);
      normal_priority_r <= pwsq_pkg::NORMAL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwsq_pkg::CFG_ACTIVE_WORKERS: begin
          active_workers_r <= cfg_data[pwsq_pkg::ACTIVE_W-1:0];
        end
        pwsq_pkg::CFG_NORMAL_PRIORITY: begin
          normal_priority_r <= cfg_data[pwsq_pkg::NORMAL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign req.action       = pwsq_pkg::action_t'(in_action);
  assign req.worker       = in_worker;
  assign req.priority_req = in_priority_req;
  assign req.job_handle   = in_job_handle;

  assign cfg.active_workers  = active_workers_r;
  assign cfg.normal_priority = normal_priority_r;

  pwsq_seq #(
    .NUM_WORKERS    (NUM_WORKERS),
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .DEQUE_DEPTH    (DEQUE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req      (req),
    .cfg      (cfg),
    .done     (seq_done),
    .done_ack (done_ack),
    .result   (seq_res)
  );

  assign done_ack = seq_done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ack) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_handle = out_res_r.handle;
  assign out_found         = out_res_r.found;
  assign out_stolen        = out_res_r.stolen;
  assign out_queue_index   = out_res_r.queue_index;
  assign out_status        = out_res_r.status;

endmodule
